/* sv/b64d_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package b64d_pkg;

	// Character codes that the decoder treats specially.
	localparam logic [7:0] CharPad    = 8'h3D;
	localparam logic [7:0] CharUpperA = 8'h41;
	localparam logic [7:0] CharUpperZ = 8'h5A;
	localparam logic [7:0] CharLowerA = 8'h61;
	localparam logic [7:0] CharLowerZ = 8'h7A;
	localparam logic [7:0] CharDigit0 = 8'h30;
	localparam logic [7:0] CharDigit9 = 8'h39;
	localparam logic [7:0] CharPlus   = 8'h2B;
	localparam logic [7:0] CharSlash  = 8'h2F;

	// Sextet values for the ranges and symbols of the alphabet.
	localparam logic [7:0] LowerBase  = 8'd26;
	localparam logic [7:0] DigitBase  = 8'd52;
	localparam logic [5:0] SextetPlus  = 6'd62;
	localparam logic [5:0] SextetSlash = 6'd63;

	// Default depth of the command queue between front and back.
	localparam int QueueDepthDefault = 4;

	// One accepted input word.
	typedef struct packed {
		logic [7:0] char_code;
		logic       last_char;
	} in_word_t;

	// One delivered result word.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_data;
		logic       msg_end;
	} out_word_t;

	// Command from the front to the back: up to three bytes of one group.
	// A byte count of zero with msg_end set is a bare end marker.
	typedef struct packed {
		logic [2:0][7:0] grp_bytes;
		logic [1:0]      nbytes;
		logic            msg_end;
	} cmd_t;

	// Maps a character to its sextet; characters outside the alphabet give zero.
	function automatic logic [5:0] sextet_of(input logic [7:0] c);
		logic [5:0] s;
		begin
			s = 6'd0;
			if (c >= CharUpperA && c <= CharUpperZ) begin
				s = 6'(c - CharUpperA);
			end else if (c >= CharLowerA && c <= CharLowerZ) begin
				s = 6'(c - CharLowerA + LowerBase);
			end else if (c >= CharDigit0 && c <= CharDigit9) begin
				s = 6'(c - CharDigit0 + DigitBase);
			end else if (c == CharPlus) begin
				s = SextetPlus;
			end else if (c == CharSlash) begin
				s = SextetSlash;
			end
			return s;
		end
	endfunction

endpackage

`default_nettype wire

/* sv/b64d_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module b64d_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             accept,
	input  wire b64d_pkg::in_word_t word,
	output logic                  push,
	output b64d_pkg::cmd_t        cmd
);
	import b64d_pkg::*;

	logic [1:0] pos_q;
	logic       twp_q;
	logic       stopped_q;
	logic [5:0] store_q [3];

	logic [1:0] pos_d;
	logic       twp_d;
	logic       stopped_d;
	logic       wr_store;
	logic [5:0] sext;
	logic       pad;
	logic       last;

	// Packs four sextets into three bytes.
	function automatic logic [2:0][7:0] pack_group(input logic [5:0] a, input logic [5:0] b,
			input logic [5:0] c, input logic [5:0] d);
		logic [2:0][7:0] r;
		begin
			r[0] = {a, b[5:4]};
			r[1] = {b[3:0], c[5:2]};
			r[2] = {c[1:0], d};
			return r;
		end
	endfunction

	assign sext = sextet_of(word.char_code);
	assign pad  = (word.char_code == CharPad);
	assign last = word.last_char;

	// Group tracking: next state and the command for this word.
	always_comb begin
		pos_d         = pos_q;
		twp_d         = twp_q;
		stopped_d     = stopped_q;
		wr_store      = 1'b0;
		push          = 1'b0;
		cmd.grp_bytes = '0;
		cmd.nbytes    = 2'd0;
		cmd.msg_end   = last;
		if (accept) begin
			if (stopped_q) begin
				push = last;
			end else begin
				unique case (pos_q)
					2'd0: begin
						if (pad) begin
							push      = last;
							stopped_d = 1'b1;
						end else begin
							wr_store      = 1'b1;
							pos_d         = 2'd1;
							push          = last;
							cmd.grp_bytes = pack_group(sext, 6'd0, 6'd0, 6'd0);
							cmd.nbytes    = 2'd3;
						end
					end
					2'd1: begin
						wr_store      = 1'b1;
						pos_d         = 2'd2;
						push          = last;
						cmd.grp_bytes = pack_group(store_q[0], sext, 6'd0, 6'd0);
						cmd.nbytes    = 2'd3;
					end
					2'd2: begin
						wr_store      = 1'b1;
						twp_d         = pad;
						pos_d         = 2'd3;
						push          = last;
						cmd.grp_bytes = pack_group(store_q[0], store_q[1], sext, 6'd0);
						cmd.nbytes    = pad ? 2'd1 : 2'd3;
					end
					default: begin
						push          = 1'b1;
						cmd.grp_bytes = pack_group(store_q[0], store_q[1], store_q[2], sext);
						if (twp_q) begin
							cmd.nbytes = 2'd1;
							stopped_d  = 1'b1;
						end else if (pad) begin
							cmd.nbytes = 2'd2;
							stopped_d  = 1'b1;
						end else begin
							cmd.nbytes = 2'd3;
						end
						pos_d = 2'd0;
						twp_d = 1'b0;
					end
				endcase
			end
			// The final character of a message returns everything to the start.
			if (last) begin
				pos_d     = 2'd0;
				twp_d     = 1'b0;
				stopped_d = 1'b0;
			end
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= 2'd0;
			twp_q     <= 1'b0;
			stopped_q <= 1'b0;
		end else begin
			pos_q     <= pos_d;
			twp_q     <= twp_d;
			stopped_q <= stopped_d;
		end
	end

	// Sextets of the current group.
	always_ff @(posedge clk) begin
		if (wr_store) begin
			store_q[pos_q] <= sext;
		end
	end

	// Decoding stops only at a group boundary.
	assert property (@(posedge clk) disable iff (!arst_n) stopped_q |-> pos_q == 2'd0)
		else $error("decoder stopped in the middle of a group");

	// A final character leaves the tracker at the start of a fresh message.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && last |=> pos_q == 2'd0 && !stopped_q && !twp_q)
		else $error("state not cleared after the final character");

	// The pad flag of the third character lives only in the last position.
	assert property (@(posedge clk) disable iff (!arst_n) twp_q |-> pos_q == 2'd3)
		else $error("third-pad flag set outside the fourth position");

endmodule

`default_nettype wire

/* sv/b64d_cmd_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none

module b64d_cmd_fifo #(
	parameter int Depth = b64d_pkg::QueueDepthDefault
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire b64d_pkg::cmd_t wr_cmd,
	input  wire logic           pop,
	output b64d_pkg::cmd_t      rd_cmd,
	output logic                full,
	output logic                empty
);
	import b64d_pkg::*;

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

	cmd_t            entry_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full   = (count_q == FullCnt);
	assign empty  = (count_q == '0);
	assign rd_cmd = entry_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_cmd;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("command pushed into a full queue");

	assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("command popped from an empty queue");

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= FullCnt)
		else $error("queue fill count out of range");

endmodule

`default_nettype wire

/* sv/b64d_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module b64d_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire b64d_pkg::cmd_t head,
	input  wire logic           empty,
	output logic                pop,
	output logic                valid,
	input  wire logic           stall,
	output b64d_pkg::out_word_t word
);
	import b64d_pkg::*;

	logic [1:0] idx_q;
	logic       valid_q;
	out_word_t  word_q;

	logic       load;
	logic [1:0] idx_end;
	logic       at_end;
	out_word_t  next_word;

	// Walk through the bytes of the head command, one word per cycle while not stalled.
	assign load    = !empty && (!valid_q || !stall);
	assign idx_end = (head.nbytes == 2'd0) ? 2'd0 : head.nbytes - 2'd1;
	assign at_end  = (idx_q == idx_end);
	assign pop     = load && at_end;

	always_comb begin
		next_word.out_byte = (head.nbytes == 2'd0) ? 8'd0 : head.grp_bytes[idx_q];
		next_word.has_data = (head.nbytes != 2'd0);
		next_word.msg_end  = head.msg_end && at_end;
	end

	// Output register and byte index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= 2'd0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= at_end ? 2'd0 : idx_q + 2'd1;
			end else if (!stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			word_q <= next_word;
		end
	end

	assign valid = valid_q;
	assign word  = word_q;

	// A command part-way through stays at the head until its last byte goes out.
	assert property (@(posedge clk) disable iff (!arst_n) idx_q != 2'd0 |-> !empty)
		else $error("partly sent command left the queue");

	// The index never passes the last byte of a group.
	assert property (@(posedge clk) disable iff (!arst_n) idx_q != 2'd3)
		else $error("byte index out of range");

	// A word without data is only ever the end marker.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !word_q.has_data |-> word_q.msg_end && word_q.out_byte == 8'd0)
		else $error("empty word that is not an end marker");

endmodule

`default_nettype wire

/* sv/base64_stream_decoder.sv */
`timescale 1ns / 1ps
`default_nettype none

// Streaming base64 decoder. It takes one text character per cycle on the chr
// channel (with a flag on the final character of a message) and returns one
// result word per cycle on the dec channel while dec_stall is low: a decoded
// byte, or a byte-less end marker when a message ends with nothing left to
// emit. A result passes a queue entry and the back's output register before it
// shows on dec_valid. The front tracks the four-character group and pushes one
// command per finished group or final character into a queue of QueueDepth
// entries; the back drains it at one byte per cycle while dec_stall is low.
// Four characters give at most three bytes, so the input runs at one character
// per cycle in steady state; a final character early in a group can release
// three bytes at once, and chr_stall rises only when the queue is full.
module base64_stream_decoder #(
	parameter int QueueDepth = b64d_pkg::QueueDepthDefault
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 chr_valid,
	output logic                      chr_stall,
	input  wire b64d_pkg::in_word_t   chr_word,
	output logic                      dec_valid,
	input  wire logic                 dec_stall,
	output b64d_pkg::out_word_t       dec_word
);
	import b64d_pkg::*;

	logic chr_accept;
	logic push;
	logic pop;
	logic full;
	logic empty;
	cmd_t wr_cmd;
	cmd_t rd_cmd;

	assign chr_stall  = full;
	assign chr_accept = chr_valid && !full;

	// Character classification and group tracking.
	b64d_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (chr_accept),
		.word   (chr_word),
		.push   (push),
		.cmd    (wr_cmd)
	);

	// Command queue between the two halves.
	b64d_cmd_fifo #(
		.Depth (QueueDepth)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (wr_cmd),
		.pop    (pop),
		.rd_cmd (rd_cmd),
		.full   (full),
		.empty  (empty)
	);

	// Byte serializer and output register.
	b64d_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (rd_cmd),
		.empty  (empty),
		.pop    (pop),
		.valid  (dec_valid),
		.stall  (dec_stall),
		.word   (dec_word)
	);

endmodule

`default_nettype wire
